// ===== hw/rtl/serial_mouse_packet_decoder_top_defines.svh =====
// assertion macros for the serial mouse packet decoder checker
// expects clk and arst_n in the scope where a macro is used
`ifndef SERIAL_MOUSE_PACKET_DECODER_TOP_DEFINES_SVH
`define SERIAL_MOUSE_PACKET_DECODER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SMPD_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("smpd check failed");

// next-cycle implication, disabled during reset
`define SMPD_ASSERT_NXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("smpd check failed");

`endif

// ===== hw/rtl/smpd_pkg.sv =====
// shared types, model table and decode helpers for the serial mouse packet decoder
// no dependencies
package smpd_pkg;

	typedef logic [7:0]         rx_byte_t;
	typedef logic [2:0]         model_code_t;
	typedef logic [2:0]         btn_t;
	typedef logic signed [15:0] motion_t;
	typedef logic signed [16:0] motion_wide_t;
	typedef logic signed [9:0]  delta_t;
	typedef logic [5:0]         count_t;
	typedef logic [2:0]         len_t;

	// protocol model codes
	localparam model_code_t MODEL_TWO_BTN = 3'd0;
	localparam model_code_t MODEL_SYS3    = 3'd1;
	localparam model_code_t MODEL_SYS5    = 3'd2;
	localparam model_code_t MODEL_SERIES  = 3'd3;
	localparam model_code_t MODEL_ALT     = 3'd4;

	localparam rx_byte_t BODY_END   = 8'h80;
	localparam count_t   COUNT_MAX  = 6'd63;
	localparam motion_t  MOTION_MAX = 16'sh7fff;
	localparam motion_t  MOTION_MIN = -16'sh8000;
	localparam btn_t     BTN_MIDDLE = 3'b100;
	localparam logic [1:0] BTN_LEFT_RIGHT = 2'b11;

	// framing rules of one protocol model
	typedef struct packed {
		rx_byte_t head_mask;
		rx_byte_t head_test;
		rx_byte_t body_mask;
		rx_byte_t body_test;
		len_t     len_min;
		len_t     len_max;
	} model_desc_t;

	// framing table, unused codes fall back to the two-button model
	function automatic model_desc_t model_desc(input model_code_t m);
		model_desc_t d;
		case (m)
			MODEL_SYS3:   d = '{8'hf8, 8'h80, 8'h00, 8'h00, 3'd3, 3'd3};
			MODEL_SYS5:   d = '{8'hf8, 8'h80, 8'h00, 8'h00, 3'd5, 3'd5};
			MODEL_SERIES: d = '{8'he0, 8'h80, 8'h80, 8'h00, 3'd3, 3'd3};
			MODEL_ALT:    d = '{8'he0, 8'h80, 8'h80, 8'h00, 3'd3, 3'd3};
			default:      d = '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3, 3'd4};
		endcase
		return d;
	endfunction

	// raw code bit0 right, bit1 middle, bit2 left -> bit0 left, bit1 right, bit2 middle
	function automatic btn_t btn_remap(input logic [2:0] code);
		return {code[1], code[0], code[2]};
	endfunction

	// sign-extend one byte
	function automatic delta_t sx8(input rx_byte_t v);
		return {{2{v[7]}}, v};
	endfunction

	// clamp to 16-bit signed range
	function automatic motion_t sat16(input motion_wide_t v);
		motion_t r;
		if (v > 17'sd32767) begin
			r = MOTION_MAX;
		end else if (v < -17'sd32768) begin
			r = MOTION_MIN;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/smpd_intf.sv =====
// valid/ready channel interfaces of the serial mouse packet decoder
// depends on smpd_pkg
interface smpd_rx_if;
	logic                valid;
	logic                ready;
	smpd_pkg::rx_byte_t  rx_byte;
	logic                last_in_burst;
	modport source (output valid, rx_byte, last_in_burst, input ready);
	modport sink (input valid, rx_byte, last_in_burst, output ready);
endinterface

interface smpd_rpt_if;
	logic                valid;
	logic                ready;
	smpd_pkg::btn_t      buttons;
	smpd_pkg::motion_t   move_x;
	smpd_pkg::motion_t   move_y;
	smpd_pkg::count_t    packet_count;
	modport source (output valid, buttons, move_x, move_y, packet_count, input ready);
	modport sink (input valid, buttons, move_x, move_y, packet_count, output ready);
endinterface

interface smpd_cfg_if;
	logic                   valid;
	logic                   ready;
	smpd_pkg::model_code_t  mouse_model;
	modport source (output valid, mouse_model, input ready);
	modport sink (input valid, mouse_model, output ready);
endinterface

// ===== hw/rtl/serial_mouse_packet_decoder_top.sv =====
// serial mouse packet decoder: frames, decodes and accumulates mouse packets
// depends on smpd_pkg and the channel interfaces in smpd_intf.sv
//
//   channel  dir  request payload
//   cfg      in   mouse_model
//   rx       in   rx_byte, last_in_burst
//   rpt      out  buttons, move_x, move_y, packet_count
//
// one byte per cycle unless rpt stalls; a byte is registered, then framed and decoded
// rpt.valid rises after the burst's last byte passes the input and output registers
// rpt is a single output register; a stall there holds the input stage and rx.ready
// arst_n clears packet position, middle flag, accumulators, model and valid flags
module serial_mouse_packet_decoder_top #(
	parameter int PACKET_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	smpd_cfg_if.sink    cfg,
	smpd_rx_if.sink     rx,
	smpd_rpt_if.source  rpt
);

	localparam int PW = $clog2(PACKET_BYTES + 1);

	// configuration
	smpd_pkg::model_code_t model_q;

	// input stage
	logic               valid_s1;
	smpd_pkg::rx_byte_t byte_s1;
	logic               last_s1;

	// packet and burst state
	logic [PW-1:0]      pos_q;
	smpd_pkg::rx_byte_t store_q [PACKET_BYTES];
	logic               middle_seen_q;
	smpd_pkg::motion_t  sum_x_q;
	smpd_pkg::motion_t  sum_y_q;
	smpd_pkg::btn_t     last_btn_q;
	smpd_pkg::count_t   burst_cnt_q;

	// output register
	logic               rpt_valid_q;
	smpd_pkg::btn_t     rpt_btn_q;
	smpd_pkg::motion_t  rpt_x_q;
	smpd_pkg::motion_t  rpt_y_q;
	smpd_pkg::count_t   rpt_cnt_q;

	// combinational
	logic                  advance;
	logic                  process;
	smpd_pkg::model_code_t sel;
	smpd_pkg::model_desc_t d;
	logic [PW-1:0]         len_min_w;
	logic [PW-1:0]         len_max_w;
	logic                  pkt_open;
	logic                  body_ok;
	logic                  store_wr;
	logic [PW-1:0]         pos_a;
	logic                  take_header;
	logic                  do_decode;
	logic                  head_ok;
	logic [PW-1:0]         pos_next;
	smpd_pkg::rx_byte_t    pkt_b [5];
	smpd_pkg::btn_t        raw_btn;
	smpd_pkg::btn_t        btn_dec;
	logic                  mid_next;
	smpd_pkg::delta_t      dx;
	smpd_pkg::delta_t      dy;
	smpd_pkg::motion_wide_t sx_w;
	smpd_pkg::motion_wide_t sy_w;
	smpd_pkg::motion_t     sx_dec;
	smpd_pkg::motion_t     sy_dec;
	smpd_pkg::btn_t        btn_last;
	smpd_pkg::count_t      cnt_dec;
	logic                  emit;

	// handshakes
	assign cfg.ready = 1'b1;
	assign advance   = !rpt_valid_q || rpt.ready;
	assign rx.ready  = !valid_s1 || advance;
	assign process   = valid_s1 && advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= smpd_pkg::MODEL_TWO_BTN;
		end else if (cfg.valid && cfg.ready) begin
			model_q <= cfg.mouse_model;
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			last_s1 <= rx.last_in_burst;
		end
	end

	// packet framing
	always_comb begin
		sel         = (model_q > smpd_pkg::MODEL_ALT) ? smpd_pkg::MODEL_TWO_BTN : model_q;
		d           = smpd_pkg::model_desc(sel);
		len_min_w   = PW'(d.len_min);
		len_max_w   = PW'(d.len_max);
		pkt_open    = pos_q != '0;
		body_ok     = ((byte_s1 & d.body_mask) == d.body_test) && (byte_s1 != smpd_pkg::BODY_END);
		store_wr    = pkt_open && body_ok && (pos_q < len_max_w)
			&& (pos_q < PW'(PACKET_BYTES));
		pos_a       = store_wr ? pos_q + PW'(1) : pos_q;
		take_header = !(pkt_open && body_ok && ((pos_a < len_min_w) || !last_s1));
		do_decode   = pkt_open && take_header && (pos_a >= len_min_w);
		head_ok     = take_header && ((byte_s1 & d.head_mask) == d.head_test);
		if (head_ok) begin
			pos_next = PW'(1);
		end else if (take_header) begin
			pos_next = '0;
		end else begin
			pos_next = pos_a;
		end
	end

	// packet bytes as seen by the decoder, including this cycle's body byte
	always_comb begin
		pkt_b[0] = store_q[0];
		for (int i = 1; i < 5; i++) begin
			pkt_b[i] = (store_wr && (pos_q == PW'(i))) ? byte_s1 : store_q[i];
		end
	end

	// per-model button and motion decode
	always_comb begin
		case (sel)
			smpd_pkg::MODEL_TWO_BTN: begin
				raw_btn = {(pos_a > len_min_w) & pkt_b[3][5], pkt_b[0][4], pkt_b[0][5]};
				dx      = smpd_pkg::sx8({pkt_b[0][1:0], pkt_b[1][5:0]});
				dy      = smpd_pkg::sx8({pkt_b[0][3:2], pkt_b[2][5:0]});
			end
			smpd_pkg::MODEL_SYS3: begin
				raw_btn = smpd_pkg::btn_remap(~pkt_b[0][2:0]);
				dx      = smpd_pkg::sx8(pkt_b[1]);
				dy      = -smpd_pkg::sx8(pkt_b[2]);
			end
			smpd_pkg::MODEL_SYS5: begin
				raw_btn = smpd_pkg::btn_remap(~pkt_b[0][2:0]);
				dx      = smpd_pkg::sx8(pkt_b[1]) + smpd_pkg::sx8(pkt_b[3]);
				dy      = -(smpd_pkg::sx8(pkt_b[2]) + smpd_pkg::sx8(pkt_b[4]));
			end
			default: begin
				raw_btn = smpd_pkg::btn_remap(pkt_b[0][2:0]);
				dx      = pkt_b[0][4] ? $signed({2'b00, pkt_b[1]}) : -$signed({2'b00, pkt_b[1]});
				dy      = pkt_b[0][3] ? -$signed({2'b00, pkt_b[2]}) : $signed({2'b00, pkt_b[2]});
			end
		endcase
	end

	// middle emulation and accumulation
	always_comb begin
		btn_dec  = raw_btn;
		mid_next = middle_seen_q;
		if (!middle_seen_q) begin
			if (raw_btn[2]) begin
				mid_next = do_decode;
			end else if (raw_btn[1:0] == smpd_pkg::BTN_LEFT_RIGHT) begin
				btn_dec = smpd_pkg::BTN_MIDDLE;
			end
		end
		sx_w     = 17'(sum_x_q) + 17'(dx);
		sy_w     = 17'(sum_y_q) - 17'(dy);
		sx_dec   = do_decode ? smpd_pkg::sat16(sx_w) : sum_x_q;
		sy_dec   = do_decode ? smpd_pkg::sat16(sy_w) : sum_y_q;
		btn_last = do_decode ? btn_dec : last_btn_q;
		cnt_dec  = (do_decode && (burst_cnt_q < smpd_pkg::COUNT_MAX))
			? burst_cnt_q + 6'd1 : burst_cnt_q;
		emit     = last_s1 && (cnt_dec != '0);
	end

	// packet and burst state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			middle_seen_q <= 1'b0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			last_btn_q    <= '0;
			burst_cnt_q   <= '0;
		end else if (process) begin
			pos_q         <= pos_next;
			middle_seen_q <= mid_next;
			if (last_s1) begin
				sum_x_q     <= '0;
				sum_y_q     <= '0;
				last_btn_q  <= '0;
				burst_cnt_q <= '0;
			end else begin
				sum_x_q     <= sx_dec;
				sum_y_q     <= sy_dec;
				last_btn_q  <= btn_last;
				burst_cnt_q <= cnt_dec;
			end
		end
	end

	// packet byte store
	always_ff @(posedge clk) begin
		if (process) begin
			for (int i = 1; i < PACKET_BYTES; i++) begin
				if (store_wr && (pos_q == PW'(i))) begin
					store_q[i] <= byte_s1;
				end
			end
			if (head_ok) begin
				store_q[0] <= byte_s1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (process && emit) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (process && emit) begin
			rpt_btn_q <= btn_last;
			rpt_x_q   <= sx_dec;
			rpt_y_q   <= sy_dec;
			rpt_cnt_q <= cnt_dec;
		end
	end

	assign rpt.valid        = rpt_valid_q;
	assign rpt.buttons      = rpt_btn_q;
	assign rpt.move_x       = rpt_x_q;
	assign rpt.move_y       = rpt_y_q;
	assign rpt.packet_count = rpt_cnt_q;

endmodule

// ===== hw/rtl/smpd_checker.sv =====
// port-level checks for the serial mouse packet decoder, bound to the top level
// depends on smpd_pkg and serial_mouse_packet_decoder_top_defines.svh
`include "serial_mouse_packet_decoder_top_defines.svh"

module smpd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rx_valid,
	input logic              rx_ready,
	input logic              rx_last,
	input logic              rpt_valid,
	input logic              rpt_ready,
	input smpd_pkg::btn_t    buttons,
	input smpd_pkg::motion_t move_x,
	input smpd_pkg::motion_t move_y,
	input smpd_pkg::count_t  packet_count
);

	logic [40:0] rpt_payload;

	// all report fields in one word
	assign rpt_payload = {buttons, move_x, move_y, packet_count};

	// a stalled report holds
	`SMPD_ASSERT_NXT(a_rpt_hold, rpt_valid && !rpt_ready, rpt_valid && $stable(rpt_payload))

	// a report always counts at least one packet
	`SMPD_ASSERT_IMP(a_rpt_count, rpt_valid, packet_count != '0)

	// a fresh report must follow an accepted burst-ending request
	`SMPD_ASSERT_IMP(a_rpt_after_last, $rose(rpt_valid), $past(rx_valid && rx_ready && rx_last, 2))

endmodule

bind serial_mouse_packet_decoder_top smpd_checker u_smpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx.valid),
	.rx_ready     (rx.ready),
	.rx_last      (rx.last_in_burst),
	.rpt_valid    (rpt.valid),
	.rpt_ready    (rpt.ready),
	.buttons      (rpt.buttons),
	.move_x       (rpt.move_x),
	.move_y       (rpt.move_y),
	.packet_count (rpt.packet_count)
);
